@@ hw/rtl/fvcs_pkg.sv @@
package fvcs_pkg;

    // status of the root unit, seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_sqrt_stat;

    // squaring passes: one per axis, plus one to fold in the last product
    localparam int unsigned SQ_PASSES = 4;

endpackage

@@ hw/rtl/fvcs_if.sv @@
interface fvcs_cell_if #(
    parameter int unsigned W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] u_low_face;
    logic signed [W-1:0] u_high_face;
    logic signed [W-1:0] v_low_face;
    logic signed [W-1:0] v_high_face;
    logic signed [W-1:0] w_low_face;
    logic signed [W-1:0] w_high_face;
    logic                last_cell;

    modport source (
        output valid, u_low_face, u_high_face, v_low_face, v_high_face,
               w_low_face, w_high_face, last_cell,
        input  ready
    );
    modport sink (
        input  valid, u_low_face, u_high_face, v_low_face, v_high_face,
               w_low_face, w_high_face, last_cell,
        output ready
    );
endinterface

interface fvcs_res_if #(
    parameter int unsigned W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] u_center;
    logic signed [W-1:0] v_center;
    logic signed [W-1:0] w_center;
    logic        [W-1:0] speed;
    logic        [W-1:0] max_speed;
    logic        [W-1:0] min_speed;
    logic                frame_done;

    modport source (
        output valid, u_center, v_center, w_center, speed, max_speed,
               min_speed, frame_done,
        input  ready
    );
    modport sink (
        input  valid, u_center, v_center, w_center, speed, max_speed,
               min_speed, frame_done,
        output ready
    );
endinterface

@@ hw/rtl/face_velocity_center_speed.sv @@
// channel | dir | modport            | payload
// i_cell  | in  | fvcs_cell_if.sink  | six face velocities, last_cell
// o_res   | out | fvcs_res_if.source | centres, speed, max/min speed, frame_done
//
// each cell is squared, then rooted, before its result is written; the root unit settles one
// root bit per cycle, and the next cell is taken in the cycle after the result is loaded
// the squares go through a single multiplier, one axis per cycle
// i_cell.ready is high only while the sequencer is idle and out of reset; a held result
// blocks the next cell only once its own result is ready to be written
// synchronous active-low reset clears the frame maximum to zero and the minimum to all ones
module face_velocity_center_speed
    import fvcs_pkg::*;
#(
    parameter int unsigned VEL_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fvcs_cell_if.sink          i_cell,
    fvcs_res_if.source         o_res
);
    localparam int unsigned W = VEL_WIDTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SQUARE,
        S_ROOT,
        S_DONE
    } t_state;

    t_state         r_state;
    logic [1:0]     r_axis;
    logic [W-1:0]   r_uc;
    logic [W-1:0]   r_vc;
    logic [W-1:0]   r_wc;
    logic           r_last;
    logic [2*W-1:0] r_prod;
    logic [2*W-1:0] r_acc;
    logic           r_sq_start;
    logic [W-1:0]   r_max;
    logic [W-1:0]   r_min;

    logic           r_out_valid;
    logic [W-1:0]   r_out_u;
    logic [W-1:0]   r_out_v;
    logic [W-1:0]   r_out_w;
    logic [W-1:0]   r_out_speed;
    logic [W-1:0]   r_out_max;
    logic [W-1:0]   r_out_min;
    logic           r_out_last;

    logic [W:0]     sum_u;
    logic [W:0]     sum_v;
    logic [W:0]     sum_w;
    logic [W-1:0]   axis_c;
    logic [W-1:0]   axis_mag;
    logic [W-1:0]   root;
    logic [W-1:0]   n_max;
    logic [W-1:0]   n_min;
    logic           cell_acc;
    logic           out_free;
    logic           out_load;
    t_sqrt_stat     sq_stat;

    // exact sums; dropping bit 0 is the floor halving
    always_comb begin
        sum_u = {i_cell.u_low_face[W-1], i_cell.u_low_face}
              + {i_cell.u_high_face[W-1], i_cell.u_high_face};
        sum_v = {i_cell.v_low_face[W-1], i_cell.v_low_face}
              + {i_cell.v_high_face[W-1], i_cell.v_high_face};
        sum_w = {i_cell.w_low_face[W-1], i_cell.w_low_face}
              + {i_cell.w_high_face[W-1], i_cell.w_high_face};
    end

    always_comb begin
        unique case (r_axis)
            2'd0:    axis_c = r_uc;
            2'd1:    axis_c = r_vc;
            default: axis_c = r_wc;
        endcase
        axis_mag = axis_c[W-1] ? (~axis_c + 1'b1) : axis_c;
    end

    always_comb begin
        n_max = (root > r_max) ? root : r_max;
        n_min = (root < r_min) ? root : r_min;
    end

    assign cell_acc = i_cell.valid && i_cell.ready;
    assign out_free = !r_out_valid || o_res.ready;
    assign out_load = (r_state == S_DONE) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= '0;
            r_sq_start  <= 1'b0;
            r_max       <= '0;
            r_min       <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_sq_start <= (r_state == S_SQUARE) && (r_axis == 2'(SQ_PASSES - 1));
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (cell_acc) begin
                        r_uc    <= sum_u[W:1];
                        r_vc    <= sum_v[W:1];
                        r_wc    <= sum_w[W:1];
                        r_last  <= i_cell.last_cell;
                        r_acc   <= '0;
                        r_axis  <= '0;
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    // each product is registered, then folded into the sum during the following axis pass
                    r_prod <= (2*W)'(axis_mag) * (2*W)'(axis_mag);
                    if (r_axis != 2'd0) begin
                        r_acc <= r_acc + r_prod;
                    end
                    if (r_axis == 2'(SQ_PASSES - 1)) begin
                        r_state <= S_ROOT;
                    end else begin
                        r_axis <= r_axis + 1'b1;
                    end
                end
                S_ROOT: begin
                    if (sq_stat.done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_u     <= r_uc;
                        r_out_v     <= r_vc;
                        r_out_w     <= r_wc;
                        r_out_speed <= root;
                        r_out_max   <= n_max;
                        r_out_min   <= n_min;
                        r_out_last  <= r_last;
                        if (r_last) begin
                            r_max <= '0;
                            r_min <= '1;
                        end else begin
                            r_max <= n_max;
                            r_min <= n_min;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    fvcs_sqrt #(
        .VEL_WIDTH (W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sq_start),
        .i_radicand (r_acc),
        .o_root     (root),
        .o_stat     (sq_stat)
    );

    assign i_cell.ready     = (r_state == S_IDLE) && i_rst_n;
    assign o_res.valid      = r_out_valid;
    assign o_res.u_center   = r_out_u;
    assign o_res.v_center   = r_out_v;
    assign o_res.w_center   = r_out_w;
    assign o_res.speed      = r_out_speed;
    assign o_res.max_speed  = r_out_max;
    assign o_res.min_speed  = r_out_min;
    assign o_res.frame_done = r_out_last;

`ifndef SYNTHESIS
    a_done_in_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_stat.done |-> (r_state == S_ROOT))
        else $error("root unit finished outside the root wait");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cell.ready |-> !sq_stat.busy)
        else $error("cell accepted while the root unit is busy");

    a_speed_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.min_speed <= o_res.speed
                         && o_res.speed <= o_res.max_speed))
        else $error("speed outside the frame minimum and maximum");
`endif

endmodule

@@ hw/rtl/fvcs_sqrt.sv @@
module fvcs_sqrt
    import fvcs_pkg::*;
#(
    parameter int unsigned VEL_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [2*VEL_WIDTH-1:0] i_radicand,
    output logic [VEL_WIDTH-1:0]   o_root,
    output t_sqrt_stat             o_stat
);
    localparam int unsigned W  = VEL_WIDTH;
    localparam int unsigned CW = $clog2(W);

    logic [2*W-1:0] r_rad;
    logic [W+1:0]   r_rem;
    logic [W-1:0]   r_root;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [W+1:0] rem_sh;
    logic [W+1:0] trial;
    logic         fits;

    // bring down the next bit pair and try root*4+1
    always_comb begin
        rem_sh = {r_rem[W-1:0], r_rad[2*W-1:2*W-2]};
        trial  = {r_root, 2'b01};
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W - 1);
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rad <= {r_rad[2*W-3:0], 2'b00};
                if (fits) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[W-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[W-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_root      = r_root;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule
